// ----- sv/pdm_pkg.sv -----
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared types, codes and helpers of the probe discharge monitor.
// ----------------------------------------------------------------------------
package pdm_pkg;

    localparam int NUM_PROBES = 3;
    localparam int VOLT_W     = 16;
    localparam int LIMIT_W    = 8;
    localparam int STEP_W     = 7;
    localparam int PROBE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [LIMIT_W-1:0]    COUNT_MAX  = 8'd255;
    localparam logic [PROBE_W-1:0]    LAST_PROBE = 2'd2;
    localparam logic [NUM_PROBES-1:0] ALL_MASK   = 3'b111;

    // request kinds
    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_READ  = 1'b1
    } func_e;

    // result status codes
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_RUNNING = 2'd1,
        ST_DONE    = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_e;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISCH_THR   = 3'd0,
        CFG_PULLDOWN    = 3'd1,
        CFG_INIT_TMO    = 3'd2,
        CFG_LOW_TMO     = 3'd3,
        CFG_LOW_VOLT    = 3'd4,
        CFG_TMO_STEP    = 3'd5
    } cfg_idx_e;

    typedef struct packed {
        logic [VOLT_W-1:0]  discharged_threshold_mv;
        logic [VOLT_W-1:0]  pulldown_below_mv;
        logic [LIMIT_W-1:0] initial_timeout;
        logic [LIMIT_W-1:0] low_start_timeout;
        logic [VOLT_W-1:0]  low_voltage_mv;
        logic [STEP_W-1:0]  timeout_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        discharged_threshold_mv: 16'd2,
        pulldown_below_mv:       16'd800,
        initial_timeout:         8'd40,
        low_start_timeout:       8'd80,
        low_voltage_mv:          16'd10,
        timeout_step:            7'd20
    };

    typedef struct packed {
        logic               func;
        logic [PROBE_W-1:0] probe;
        logic [VOLT_W-1:0]  voltage_mv;
    } item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [PROBE_W-1:0]    next_probe;
        logic [NUM_PROBES-1:0] pulldown_mask;
        logic [PROBE_W-1:0]    error_probe;
        logic [VOLT_W-1:0]     error_voltage_mv;
    } result_t;

    // next probe after p, round-robin, that is not yet discharged
    function automatic logic [PROBE_W-1:0] next_open(
        input logic [PROBE_W-1:0]    p,
        input logic [NUM_PROBES-1:0] mask
    );
        logic [PROBE_W-1:0] q;
        logic [PROBE_W-1:0] r;
        logic               found;
        q     = p;
        r     = '0;
        found = 1'b0;
        for (int k = 0; k < NUM_PROBES; k++)
        begin
            q = (q >= LAST_PROBE) ? '0 : PROBE_W'(q + 1'b1);
            if (!found && !mask[q])
            begin
                r     = q;
                found = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/pdm_if.sv -----
// ----------------------------------------------------------------------------
// pdm_if
// Valid/ready channels for probe samples and monitor results.
// ----------------------------------------------------------------------------
interface pdm_sample_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [pdm_pkg::PROBE_W-1:0]  probe;
    logic [pdm_pkg::VOLT_W-1:0]   voltage_mv;

    modport source (output valid, func, probe, voltage_mv, input ready);
    modport sink   (input valid, func, probe, voltage_mv, output ready);
endinterface

interface pdm_result_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [pdm_pkg::PROBE_W-1:0]    next_probe;
    logic [pdm_pkg::NUM_PROBES-1:0] pulldown_mask;
    logic [pdm_pkg::PROBE_W-1:0]    error_probe;
    logic [pdm_pkg::VOLT_W-1:0]     error_voltage_mv;

    modport source (output valid, status, next_probe, pulldown_mask, error_probe,
                    error_voltage_mv, input ready);
    modport sink   (input valid, status, next_probe, pulldown_mask, error_probe,
                    error_voltage_mv, output ready);
endinterface

// ----- sv/pdm_cfg.sv -----
// ----------------------------------------------------------------------------
// pdm_cfg
// Configuration register file, write-only, reset to default thresholds.
// ----------------------------------------------------------------------------
module pdm_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pdm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output pdm_pkg::cfg_t                     cfg
);

    pdm_pkg::cfg_t cfg_reg;
    pdm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pdm_pkg::CFG_DISCH_THR: cfg_next.discharged_threshold_mv = cfg_wdata;
                pdm_pkg::CFG_PULLDOWN:  cfg_next.pulldown_below_mv       = cfg_wdata;
                pdm_pkg::CFG_INIT_TMO:
                    cfg_next.initial_timeout   = cfg_wdata[pdm_pkg::LIMIT_W-1:0];
                pdm_pkg::CFG_LOW_TMO:
                    cfg_next.low_start_timeout = cfg_wdata[pdm_pkg::LIMIT_W-1:0];
                pdm_pkg::CFG_LOW_VOLT:  cfg_next.low_voltage_mv          = cfg_wdata;
                pdm_pkg::CFG_TMO_STEP:
                    cfg_next.timeout_step      = cfg_wdata[pdm_pkg::STEP_W-1:0];
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= pdm_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/pdm_core.sv -----
// ----------------------------------------------------------------------------
// pdm_core
// Run state of the monitor and the per-request step logic.
// ----------------------------------------------------------------------------
module pdm_core (
    input  logic             clk,
    input  logic             rst_n,
    input  pdm_pkg::cfg_t    cfg,
    input  logic             step,   // commit the request in item
    input  pdm_pkg::item_t   item,
    output pdm_pkg::result_t res
);

    localparam int NP = pdm_pkg::NUM_PROBES;
    localparam int PW = pdm_pkg::PROBE_W;
    localparam int VW = pdm_pkg::VOLT_W;
    localparam int LW = pdm_pkg::LIMIT_W;

    logic [VW-1:0] last_v_reg [NP];
    logic [VW-1:0] last_v_next [NP];
    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] limit_reg, limit_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [NP-1:0] dmask_reg, dmask_next;
    logic [NP-1:0] pmask_reg, pmask_next;
    logic          run_reg, run_next;

    logic [PW-1:0] id;
    logic [VW-1:0] last_sel;
    logic          drop;
    logic          close;
    logic          room;
    logic [LW+1:0] count_plus_step;

    always_comb
    begin
        last_v_next = last_v_reg;
        count_next  = count_reg;
        limit_next  = limit_reg;
        cur_next    = cur_reg;
        dmask_next  = dmask_reg;
        pmask_next  = pmask_reg;
        run_next    = run_reg;
        res         = '0;
        res.status  = pdm_pkg::ST_IDLE;

        id              = pdm_pkg::next_open(cur_reg, dmask_reg);
        last_sel        = last_v_reg[id];
        drop            = item.voltage_mv < last_sel;
        // limit - count < step, kept unsigned
        count_plus_step = (LW+2)'(count_reg) + (LW+2)'(cfg.timeout_step);
        close           = (LW+2)'(limit_reg) < count_plus_step;
        room            = limit_reg < LW'(pdm_pkg::COUNT_MAX - LW'(cfg.timeout_step));

        if (item.func == pdm_pkg::FUNC_START)
        begin
            if (item.probe < PW'(NP))
                last_v_next[item.probe] = item.voltage_mv;
            count_next     = LW'(1);
            limit_next     = cfg.initial_timeout;
            cur_next       = pdm_pkg::LAST_PROBE;
            dmask_next     = '0;
            pmask_next     = '0;
            run_next       = 1'b1;
            res.status     = pdm_pkg::ST_RUNNING;
            res.next_probe = pdm_pkg::next_open(pdm_pkg::LAST_PROBE, '0);
        end
        else if (run_reg)
        begin
            cur_next = id;
            if (drop)
            begin
                last_v_next[id] = item.voltage_mv;
                if (close && room)
                    limit_next = LW'(limit_reg + LW'(cfg.timeout_step));
                count_next = LW'(1);
            end
            else
            begin
                if (item.voltage_mv < cfg.low_voltage_mv && limit_reg <= cfg.initial_timeout)
                    limit_next = cfg.low_start_timeout;
                if (count_reg < pdm_pkg::COUNT_MAX)
                    count_next = LW'(count_reg + 1'b1);
            end

            if (item.voltage_mv <= cfg.discharged_threshold_mv)
                dmask_next = dmask_reg | NP'(1 << id);
            else if (item.voltage_mv < cfg.pulldown_below_mv)
                pmask_next = pmask_reg | NP'(1 << id);

            if (dmask_next == pdm_pkg::ALL_MASK)
            begin
                res.status = pdm_pkg::ST_DONE;
                run_next   = 1'b0;
                pmask_next = '0;
            end
            else if (count_next > limit_next)
            begin
                res.status           = pdm_pkg::ST_TIMEOUT;
                res.error_probe      = id;
                res.error_voltage_mv = item.voltage_mv;
                run_next             = 1'b0;
                pmask_next           = '0;
            end
            else
            begin
                res.status        = pdm_pkg::ST_RUNNING;
                res.next_probe    = pdm_pkg::next_open(id, dmask_next);
                res.pulldown_mask = pmask_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NP; i++)
                last_v_reg[i] <= '0;
            count_reg <= LW'(1);
            limit_reg <= pdm_pkg::CFG_RESET.initial_timeout;
            cur_reg   <= pdm_pkg::LAST_PROBE;
            dmask_reg <= '0;
            pmask_reg <= '0;
            run_reg   <= 1'b0;
        end
        else if (step)
        begin
            last_v_reg <= last_v_next;
            count_reg  <= count_next;
            limit_reg  <= limit_next;
            cur_reg    <= cur_next;
            dmask_reg  <= dmask_next;
            pmask_reg  <= pmask_next;
            run_reg    <= run_next;
        end
    end

    // a run never survives with every probe discharged
    a_run_not_all_done: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (dmask_reg != pdm_pkg::ALL_MASK))
        else $error("run still active with all probes discharged");

    // counter restarts at one and saturates, never zero
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0)
        else $error("no-drop counter reached zero");

    // visited probe stays a real probe
    a_cur_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg < PW'(NP))
        else $error("current probe out of range");

    // a reading while stopped changes nothing
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !run_reg && item.func == pdm_pkg::FUNC_READ)
        |=> ($stable(count_reg) && $stable(limit_reg) && !run_reg))
        else $error("idle reading altered run state");

endmodule

// ----- sv/probe_discharge_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// probe_discharge_monitor_unit
// Supervises the discharge of three test probes and reports progress,
// completion, a timeout or the idle state per request.
// ----------------------------------------------------------------------------
//  channel   kind        payload                                     dir
//  -------   ---------   -----------------------------------------   ---
//  sample    valid/rdy   func, probe, voltage_mv                     in
//  result    valid/rdy   status, next_probe, pulldown_mask,          out
//                        error_probe, error_voltage_mv
//  cfg       write only  cfg_we, cfg_index, cfg_wdata                in
//
//  Flow: an accepted request sits in the input register, then commits
//  through the step logic into the result register; one request per
//  cycle while results are taken, set by the single step stage in pdm_core.
//  Reset: rst_n async, clears the valid flags of both stages, the run
//  state and the config registers to their defaults.
//  Stalls: the result register holds until taken; the input register keeps
//  accepting while it is empty or the result register is free to load.
// ----------------------------------------------------------------------------
module probe_discharge_monitor_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    pdm_sample_if.sink                      sample,
    pdm_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [pdm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    pdm_pkg::cfg_t    cfg;
    pdm_pkg::item_t   item_reg, item_next;
    pdm_pkg::result_t res_comb;
    pdm_pkg::result_t res_reg, res_next;
    logic             in_vld_reg, in_vld_next;
    logic             res_vld_reg, res_vld_next;
    logic             out_free;     // result register can load this cycle
    logic             advance;      // input stage commits into result stage
    logic             take;         // sample request accepted

    pdm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdm_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .item  (item_reg),
        .res   (res_comb)
    );

    // handshake
    assign out_free     = !res_vld_reg || result.ready;
    assign advance      = in_vld_reg && out_free;
    assign sample.ready = !in_vld_reg || out_free;
    assign take         = sample.valid && sample.ready;

    always_comb
    begin
        item_next  = item_reg;
        res_next   = res_reg;
        if (take)
        begin
            item_next.func       = sample.func;
            item_next.probe      = sample.probe;
            item_next.voltage_mv = sample.voltage_mv;
        end
        if (advance)
            res_next = res_comb;

        in_vld_next  = take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        res_vld_next = advance ? 1'b1 : (result.ready ? 1'b0 : res_vld_reg);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign result.valid            = res_vld_reg;
    assign result.status           = res_reg.status;
    assign result.next_probe       = res_reg.next_probe;
    assign result.pulldown_mask    = res_reg.pulldown_mask;
    assign result.error_probe      = res_reg.error_probe;
    assign result.error_voltage_mv = res_reg.error_voltage_mv;

    // a committed request always shows up as a result next cycle
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_vld_reg)
        else $error("committed request produced no result");

    // a pending request with a blocked result stage stays pending
    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_free) |=> in_vld_reg)
        else $error("pending request lost while result stalled");

    // pulldown is only reported on running results
    a_pull_running: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && res_reg.status != pdm_pkg::ST_RUNNING)
        |-> (res_reg.pulldown_mask == '0))
        else $error("pulldown reported outside a run");

endmodule
